// ----- design/affine_matrix_engine_defines.svh -----
// Assertion macros for the affine matrix engine checker.
// Needs aclk and aresetn in the scope where a macro is used.
`ifndef AFFINE_MATRIX_ENGINE_DEFINES_SVH
`define AFFINE_MATRIX_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define AME_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define AME_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/ame_pkg.sv -----
// Shared types and codes for the affine matrix engine.
// No dependencies; imported by every module of the engine.
`timescale 1ns / 1ps

package ame_pkg;

    localparam int DATA_W = 32;
    localparam int OPA_W  = DATA_W + 1;   // operand A carries an exact negation

    localparam logic [2:0] MODE_WR_CUR = 3'd0;
    localparam logic [2:0] MODE_WR_OPR = 3'd1;
    localparam logic [2:0] MODE_IDENT  = 3'd2;
    localparam logic [2:0] MODE_CONCAT = 3'd3;
    localparam logic [2:0] MODE_INVERT = 3'd4;
    localparam logic [2:0] MODE_XFORM  = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } state_t;

    // Sequencer phases: transform rows, concatenate row fill and MAC,
    // invert translation fill, translation MAC and rotation swap.
    typedef enum logic [2:0] {
        PH_T,
        PH_CF,
        PH_CM,
        PH_IT,
        PH_IM,
        PH_IS
    } phase_t;

    typedef enum logic [1:0] {
        DST_CUR,
        DST_SAVE,
        DST_OUT
    } dst_t;

    typedef enum logic [1:0] {
        A_RDC,
        A_ROW,
        A_NEGT,
        A_SAVE
    } a_sel_t;

    typedef enum logic [1:0] {
        B_RDO,
        B_RDC,
        B_VEC,
        B_ONE
    } b_sel_t;

    typedef enum logic [1:0] {
        CAP_NONE,
        CAP_ROW,
        CAP_T
    } cap_t;

    typedef struct packed {
        logic       first;
        logic       last;
        dst_t       dst;
        logic [3:0] idx;
    } mac_ctl_t;

    typedef struct packed {
        logic     vld;
        cap_t     cap;
        a_sel_t   a_sel;
        b_sel_t   b_sel;
        logic [1:0] k;
        mac_ctl_t ctl;
    } term_t;

endpackage

// ----- design/ame_mat_mem.sv -----
// 16-entry matrix store with one write and one registered read port.
// Per-entry valid bits give the reset contents; clear restores them at once.
`timescale 1ns / 1ps

module ame_mat_mem import ame_pkg::*; #(
    parameter logic [31:0] DIAG_VAL = 32'h0001_0000
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clear,
    input  logic              we,
    input  logic [3:0]        waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [3:0]        raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [16];
    logic [15:0]       valid_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic [DATA_W-1:0] rst_val;

    // Unwritten entries read as DIAG_VAL on the diagonal and zero elsewhere.
    assign rst_val = (raddr[3:2] == raddr[1:0]) ? DIAG_VAL : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= valid_reg[raddr] ? mem[raddr] : rst_val;
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/ame_mac.sv -----
// Shared multiply-accumulate unit: registered product, floor shift by
// FRAC_BITS, exact accumulate and 32-bit saturation. Uses ame_pkg.
`timescale 1ns / 1ps

module ame_mac import ame_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_vld,
    input  mac_ctl_t                 in_ctl,
    input  logic signed [OPA_W-1:0]  op_a,
    input  logic signed [DATA_W-1:0] op_b,
    output logic                     res_vld,
    output mac_ctl_t                 res_ctl,
    output logic [DATA_W-1:0]        res_data
);

    localparam int PROD_W = OPA_W + DATA_W;
    localparam int SH_W   = PROD_W - FRAC_BITS;
    localparam int ACC_W  = SH_W + 2;          // room for four terms

    logic                     prod_vld_reg;
    mac_ctl_t                 ctl_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [SH_W-1:0]   sh;
    logic [ACC_W-DATA_W:0]    hi_bits;
    logic                     fits;

    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_vld) begin
            prod_reg <= prod_next;
            ctl_reg  <= in_ctl;
        end
        if (prod_vld_reg) begin
            acc_reg <= acc_next;
        end
    end

    // Dropping the low bits of a two's complement value rounds toward minus infinity.
    assign sh       = prod_reg[PROD_W-1:FRAC_BITS];
    assign acc_next = (ctl_reg.first ? ACC_W'(0) : acc_reg) + ACC_W'(sh);
    assign hi_bits  = acc_next[ACC_W-1:DATA_W-1];
    assign fits     = (&hi_bits) | ~(|hi_bits);

    assign res_vld  = prod_vld_reg;
    assign res_ctl  = ctl_reg;
    assign res_data = fits ? acc_next[DATA_W-1:0]
                    : (acc_next[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                         : {1'b0, {(DATA_W-1){1'b1}}});

endmodule

// ----- design/affine_matrix_engine.sv -----
// Affine 4x4 matrix engine, Q(32-FRAC_BITS).FRAC_BITS, one shared MAC under a sequencer.
// Cell writes, identity and unused modes leave the input ready. Transform issues its MAC
// terms, drains the pipeline and loads the output; concatenate and rigid invert issue
// and drain their terms, all paced by the one multiplier and the single read port of each
// matrix. Reset is synchronous, active low: current matrix reads as identity, operand as
// zeros. Depends on ame_pkg, ame_mat_mem, ame_mac.
`timescale 1ns / 1ps

module affine_matrix_engine import ame_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cell_index[3:0], cell_value[35:4], vec_x[67:36], vec_y[99:68], vec_z[131:100]
    input  logic [135:0] s_tdata,
    // mode[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [95:0]  m_tdata
);

    localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

    logic [2:0]        in_mode;
    logic [3:0]        in_idx;
    logic [DATA_W-1:0] in_val;
    logic              s_accept;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next, phase_adv;
    logic [1:0] hi_reg, hi_next, hi_adv;
    logic [3:0] lo_reg, lo_next, lo_adv;
    logic       xform_reg, xform_next;
    logic       run_done;
    logic       issue;
    logic       drained;
    logic       load_out;

    term_t      term;
    term_t      s1_reg;
    logic [3:0] c_raddr;
    logic [3:0] o_raddr;

    logic [DATA_W-1:0] vec_reg [3];
    logic [DATA_W-1:0] rowbuf_reg [4];
    logic [DATA_W-1:0] tbuf_reg [3];
    logic [DATA_W-1:0] save_reg;
    logic [DATA_W-1:0] stg_reg [3];
    logic [95:0]       m_tdata_reg;
    logic              m_tvalid_reg, m_tvalid_next;

    logic [DATA_W-1:0] c_rdata, o_rdata;
    logic              c_we, c_clear, o_we;
    logic [3:0]        c_waddr;
    logic [DATA_W-1:0] c_wdata;

    logic signed [OPA_W-1:0]  op_a;
    logic signed [DATA_W-1:0] op_b;
    logic [DATA_W-1:0]        t_sel, v_sel;
    logic                     res_vld, res_wr;
    mac_ctl_t                 res_ctl;
    logic [DATA_W-1:0]        res_data;

    // Off-diagonal pairs of the 3x3 part, swapped in place during invert.
    function automatic logic [3:0] swap_lo(input logic [1:0] p);
        case (p)
            2'd0:    swap_lo = 4'd1;
            2'd1:    swap_lo = 4'd2;
            default: swap_lo = 4'd6;
        endcase
    endfunction

    function automatic logic [3:0] swap_hi(input logic [1:0] p);
        case (p)
            2'd0:    swap_hi = 4'd4;
            2'd1:    swap_hi = 4'd8;
            default: swap_hi = 4'd9;
        endcase
    endfunction

    assign in_mode  = s_tuser;
    assign in_idx   = s_tdata[3:0];
    assign in_val   = s_tdata[35:4];
    assign s_accept = s_tvalid && s_tready;

    // ---------------------------------------------------------------- FSM
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && (in_mode == MODE_CONCAT || in_mode == MODE_INVERT ||
                                 in_mode == MODE_XFORM)) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (run_done) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drained) begin
                    state_next = xform_reg ? ST_OUT : ST_IDLE;
                end
            end
            ST_OUT: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        issue    = (state_reg == ST_RUN);
        drained  = !s1_reg.vld && !res_vld;
        load_out = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------ term sequencer
    always_comb begin
        term       = '0;
        c_raddr    = '0;
        o_raddr    = '0;
        phase_adv  = phase_reg;
        hi_adv     = hi_reg;
        lo_adv     = lo_reg + 4'd1;
        run_done   = 1'b0;
        term.k     = lo_reg[1:0];
        term.b_sel = B_ONE;
        case (phase_reg)
            PH_T: begin
                // row r: three vector products, then the translation times one
                c_raddr        = {hi_reg, lo_reg[1:0]};
                term.a_sel     = A_RDC;
                term.b_sel     = (lo_reg[1:0] == 2'd3) ? B_ONE : B_VEC;
                term.ctl.first = (lo_reg[1:0] == 2'd0);
                term.ctl.last  = (lo_reg[1:0] == 2'd3);
                term.ctl.dst   = DST_OUT;
                term.ctl.idx   = {2'b00, hi_reg};
                if (lo_reg[1:0] == 2'd3) begin
                    lo_adv   = '0;
                    hi_adv   = hi_reg + 2'd1;
                    run_done = (hi_reg == 2'd2);
                end
            end
            PH_CF: begin
                c_raddr  = {hi_reg, lo_reg[1:0]};
                term.cap = CAP_ROW;
                if (lo_reg[1:0] == 2'd3) begin
                    lo_adv    = '0;
                    phase_adv = PH_CM;
                end
            end
            PH_CM: begin
                // lo = column*4 + k
                o_raddr        = {lo_reg[1:0], lo_reg[3:2]};
                term.a_sel     = A_ROW;
                term.b_sel     = B_RDO;
                term.ctl.first = (lo_reg[1:0] == 2'd0);
                term.ctl.last  = (lo_reg[1:0] == 2'd3);
                term.ctl.dst   = DST_CUR;
                term.ctl.idx   = {hi_reg, lo_reg[3:2]};
                if (lo_reg == 4'd15) begin
                    lo_adv    = '0;
                    hi_adv    = hi_reg + 2'd1;
                    phase_adv = PH_CF;
                    run_done  = (hi_reg == 2'd3);
                end
            end
            PH_IT: begin
                c_raddr  = {lo_reg[1:0], 2'd3};
                term.cap = CAP_T;
                if (lo_reg[1:0] == 2'd2) begin
                    lo_adv    = '0;
                    hi_adv    = '0;
                    phase_adv = PH_IM;
                end
            end
            PH_IM: begin
                // new T[i] from old column i of the rotation and the negated translation
                c_raddr        = {lo_reg[1:0], hi_reg};
                term.a_sel     = A_NEGT;
                term.b_sel     = B_RDC;
                term.ctl.first = (lo_reg[1:0] == 2'd0);
                term.ctl.last  = (lo_reg[1:0] == 2'd2);
                term.ctl.dst   = DST_CUR;
                term.ctl.idx   = {hi_reg, 2'd3};
                if (lo_reg[1:0] == 2'd2) begin
                    lo_adv = '0;
                    if (hi_reg == 2'd2) begin
                        hi_adv    = '0;
                        phase_adv = PH_IS;
                    end else begin
                        hi_adv = hi_reg + 2'd1;
                    end
                end
            end
            PH_IS: begin
                // save the upper cell, copy the lower into it, write the saved one back
                term.ctl.first = 1'b1;
                term.ctl.last  = 1'b1;
                case (lo_reg[1:0])
                    2'd0: begin
                        c_raddr      = swap_lo(hi_reg);
                        term.a_sel   = A_RDC;
                        term.ctl.dst = DST_SAVE;
                    end
                    2'd1: begin
                        c_raddr      = swap_hi(hi_reg);
                        term.a_sel   = A_RDC;
                        term.ctl.dst = DST_CUR;
                        term.ctl.idx = swap_lo(hi_reg);
                    end
                    default: begin
                        term.a_sel   = A_SAVE;
                        term.ctl.dst = DST_CUR;
                        term.ctl.idx = swap_hi(hi_reg);
                    end
                endcase
                if (lo_reg[1:0] == 2'd2) begin
                    lo_adv   = '0;
                    hi_adv   = hi_reg + 2'd1;
                    run_done = (hi_reg == 2'd2);
                end
            end
            default: run_done = 1'b1;
        endcase
        term.vld = issue;
    end

    always_comb begin
        phase_next = phase_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        xform_next = xform_reg;
        if (s_accept) begin
            hi_next    = '0;
            lo_next    = '0;
            xform_next = (in_mode == MODE_XFORM);
            case (in_mode)
                MODE_CONCAT: phase_next = PH_CF;
                MODE_INVERT: phase_next = PH_IT;
                default:     phase_next = PH_T;
            endcase
        end else if (issue) begin
            phase_next = phase_adv;
            hi_next    = hi_adv;
            lo_next    = lo_adv;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_T;
            hi_reg    <= '0;
            lo_reg    <= '0;
            xform_reg <= 1'b0;
            s1_reg    <= '0;
        end else begin
            phase_reg <= phase_next;
            hi_reg    <= hi_next;
            lo_reg    <= lo_next;
            xform_reg <= xform_next;
            s1_reg    <= term;
        end
    end

    // ------------------------------------------------------------ storage
    assign res_wr  = res_vld && res_ctl.last;
    assign c_clear = s_accept && (in_mode == MODE_IDENT);
    assign c_we    = (s_accept && in_mode == MODE_WR_CUR) || (res_wr && res_ctl.dst == DST_CUR);
    assign c_waddr = (state_reg == ST_IDLE) ? in_idx : res_ctl.idx;
    assign c_wdata = (state_reg == ST_IDLE) ? in_val : res_data;
    assign o_we    = s_accept && (in_mode == MODE_WR_OPR);

    ame_mat_mem #(
        .DIAG_VAL (ONE)
    ) u_cur_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (c_clear),
        .we      (c_we),
        .waddr   (c_waddr),
        .wdata   (c_wdata),
        .raddr   (c_raddr),
        .rdata   (c_rdata)
    );

    ame_mat_mem #(
        .DIAG_VAL ('0)
    ) u_opr_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (1'b0),
        .we      (o_we),
        .waddr   (in_idx),
        .wdata   (in_val),
        .raddr   (o_raddr),
        .rdata   (o_rdata)
    );

    // ---------------------------------------------------- operand select
    always_comb begin
        case (s1_reg.k)
            2'd0:    t_sel = tbuf_reg[0];
            2'd1:    t_sel = tbuf_reg[1];
            default: t_sel = tbuf_reg[2];
        endcase
        case (s1_reg.k)
            2'd0:    v_sel = vec_reg[0];
            2'd1:    v_sel = vec_reg[1];
            default: v_sel = vec_reg[2];
        endcase
    end

    always_comb begin
        case (s1_reg.a_sel)
            A_RDC:   op_a = {c_rdata[DATA_W-1], c_rdata};
            A_ROW:   op_a = {rowbuf_reg[s1_reg.k][DATA_W-1], rowbuf_reg[s1_reg.k]};
            A_NEGT:  op_a = -{t_sel[DATA_W-1], t_sel};
            A_SAVE:  op_a = {save_reg[DATA_W-1], save_reg};
            default: op_a = '0;
        endcase
        case (s1_reg.b_sel)
            B_RDO:   op_b = o_rdata;
            B_RDC:   op_b = c_rdata;
            B_VEC:   op_b = v_sel;
            B_ONE:   op_b = ONE;
            default: op_b = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            vec_reg[0] <= s_tdata[67:36];
            vec_reg[1] <= s_tdata[99:68];
            vec_reg[2] <= s_tdata[131:100];
        end
        if (s1_reg.vld && s1_reg.cap == CAP_ROW) begin
            rowbuf_reg[s1_reg.k] <= c_rdata;
        end
        if (s1_reg.vld && s1_reg.cap == CAP_T) begin
            case (s1_reg.k)
                2'd0:    tbuf_reg[0] <= c_rdata;
                2'd1:    tbuf_reg[1] <= c_rdata;
                default: tbuf_reg[2] <= c_rdata;
            endcase
        end
    end

    ame_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_vld   (s1_reg.vld && s1_reg.cap == CAP_NONE),
        .in_ctl   (s1_reg.ctl),
        .op_a     (op_a),
        .op_b     (op_b),
        .res_vld  (res_vld),
        .res_ctl  (res_ctl),
        .res_data (res_data)
    );

    // ------------------------------------------------------- result side
    always_ff @(posedge aclk) begin
        if (res_wr && res_ctl.dst == DST_SAVE) begin
            save_reg <= res_data;
        end
        if (res_wr && res_ctl.dst == DST_OUT) begin
            case (res_ctl.idx[1:0])
                2'd0:    stg_reg[0] <= res_data;
                2'd1:    stg_reg[1] <= res_data;
                default: stg_reg[2] <= res_data;
            endcase
        end
        if (load_out) begin
            m_tdata_reg <= {stg_reg[2], stg_reg[1], stg_reg[0]};
        end
    end

    // hold the beat until taken; a new load may replace it in the cycle it is taken
    assign m_tvalid_next = load_out ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- design/ame_checker.sv -----
// Port-level checker for the affine matrix engine, bound to the top level.
// Depends on ame_pkg and affine_matrix_engine_defines.svh.
`timescale 1ns / 1ps
`include "affine_matrix_engine_defines.svh"

module ame_checker import ame_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);

    `AME_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")

    `AME_ASSERT_NEXT(a_busy_after_op, s_tvalid && s_tready && (s_tuser == MODE_CONCAT || s_tuser == MODE_INVERT || s_tuser == MODE_XFORM), !s_tready, "ready high right after a compute beat")

    `AME_ASSERT_NEXT(a_ready_after_write, s_tvalid && s_tready && (s_tuser == MODE_WR_CUR || s_tuser == MODE_WR_OPR || s_tuser == MODE_IDENT), s_tready, "ready dropped after a single-cycle beat")

    `AME_ASSERT_SAME(a_out_from_run, $rose(m_tvalid), !$past(s_tready), "result appeared while input side was idle")

endmodule

bind affine_matrix_engine ame_checker u_ame_checker (.*);

// ----- dv/tb_top.sv -----
// Self-checking testbench for affine_matrix_engine: directed table, then random beats.
// Keeps its own fixed-point copy of both matrices to predict transform results.
// Depends on ame_pkg and the engine RTL only.
`timescale 1ns / 1ps

module tb_top import ame_pkg::*; ();

    localparam int FRAC         = 16;
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 9;
    localparam int PHASE_ITEMS  = 350;
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 1_000_000;

    // Modes the engine leaves unused
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    localparam logic [31:0] Q_ONE     = 32'h0001_0000;
    localparam logic [31:0] Q_HALF    = 32'h0000_8000;
    localparam logic [31:0] Q_TWO     = 32'h0002_0000;
    localparam logic [31:0] Q_THREE   = 32'h0003_0000;
    localparam logic [31:0] Q_NEG1    = 32'hFFFF_0000;
    localparam logic [31:0] Q_NEG_2P5 = 32'hFFFD_8000;
    localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN     = 32'h8000_0000;
    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;

    localparam longint SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint SAT_LO = -64'sh0000_0000_8000_0000;

    typedef struct {
        logic [2:0]         mode;
        logic [3:0]         idx;
        logic signed [31:0] val;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
    } op_beat_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } xyz_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  idx;
        logic [31:0] val;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic        chk;
        logic [31:0] ex;
        logic [31:0] ey;
        logic [31:0] ez;
    } dir_row_t;

    localparam int DIR_ROWS = 24;
    // chk set: expected x, y, z typed in; otherwise the predictor decides
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{MODE_XFORM,   4'd0,  32'h0,        Q_ONE, Q_NEG_2P5, Q_THREE,
          1'b1, Q_ONE, Q_NEG_2P5, Q_THREE},
        '{MODE_XFORM,   4'd15, Q_MAX,        Q_MAX, Q_MIN, 32'h0,
          1'b1, Q_MAX, Q_MIN, 32'h0},
        '{MODE_XFORM,   4'd6,  Q_MIN,        ALL_ONES, ALL_ONES, ALL_ONES,
          1'b1, ALL_ONES, ALL_ONES, ALL_ONES},
        '{MODE_SPARE_6, 4'd9,  32'hA5A5_5A5A, 32'hDEAD_BEEF, 32'h1234_5678, Q_MIN,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{MODE_SPARE_7, 4'd14, 32'h5A5A_A5A5, Q_MAX, 32'h8765_4321, 32'hCAFE_F00D,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{MODE_WR_OPR,  4'd0,  Q_TWO,        32'hFFFF_FFFF, 32'h0, 32'h1,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{MODE_WR_OPR,  4'd5,  Q_HALF,       32'h0, 32'h0, 32'h0,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{MODE_WR_OPR,  4'd10, Q_NEG1,       32'h0, 32'h0, 32'h0,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{MODE_WR_OPR,  4'd15, Q_ONE,        32'h0, 32'h0, 32'h0,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{MODE_WR_OPR,  4'd3,  32'h000A_4000, 32'h0, 32'h0, 32'h0,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{MODE_WR_OPR,  4'd12, Q_MAX,        32'h0, 32'h0, 32'h0,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{MODE_CONCAT,  4'd7,  Q_MIN,        Q_MAX, Q_MAX, Q_MAX,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{MODE_XFORM,   4'd0,  32'h0,        Q_ONE, Q_TWO, Q_THREE,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{MODE_WR_CUR,  4'd3,  Q_MAX,        32'h0, 32'h0, 32'h0,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{MODE_WR_CUR,  4'd0,  Q_MIN,        32'h0, 32'h0, 32'h0,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{MODE_XFORM,   4'd0,  32'h0,        Q_MAX, Q_MIN, Q_MAX,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{MODE_WR_CUR,  4'd7,  Q_MIN,        32'h0, 32'h0, 32'h0,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{MODE_INVERT,  4'd2,  32'h1357_9BDF, ALL_ONES, Q_MIN, Q_ONE,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{MODE_XFORM,   4'd0,  32'h0,        Q_NEG1, Q_HALF, Q_MIN,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{MODE_CONCAT,  4'd0,  32'h0,        32'h0, 32'h0, 32'h0,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{MODE_INVERT,  4'd0,  32'h0,        32'h0, 32'h0, 32'h0,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{MODE_IDENT,   4'd11, ALL_ONES,     Q_MIN, Q_MAX, ALL_ONES,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{MODE_XFORM,   4'd0,  32'h0,        Q_MIN, Q_MIN, Q_MIN,
          1'b1, Q_MIN, Q_MIN, Q_MIN},
        '{MODE_WR_CUR,  4'd15, 32'h0000_1234, 32'h0, 32'h0, 32'h0,
          1'b0, 32'h0, 32'h0, 32'h0}
    };

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [135:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;

    logic signed [31:0] cur_mat [16];
    logic signed [31:0] opr_mat [16];
    xyz_t               pending_xyz [$];

    int idle_pct;
    int stall_pct;
    int fail_cnt  = 0;
    int cycle_cnt = 0;

    affine_matrix_engine #(
        .FRAC_BITS (FRAC)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Full-precision product, floor-shifted back to the fixed-point scale
    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> FRAC;
    endfunction

    function automatic logic signed [31:0] sat32(longint v);
        if (v > SAT_HI) return Q_MAX;
        if (v < SAT_LO) return Q_MIN;
        return v[31:0];
    endfunction

    task automatic load_identity();
        for (int i = 0; i < 16; i++) cur_mat[i] = (i % 5 == 0) ? Q_ONE : 32'h0;
    endtask

    task automatic engine_step(input op_beat_t b, output bit gives, output xyz_t res);
        logic signed [31:0] prod_mat [16];
        logic signed [31:0] rot [9];
        longint             negt [3];
        longint             vec [3];
        logic signed [31:0] outv [3];
        longint             acc;
        gives = 1'b0;
        res   = '{32'h0, 32'h0, 32'h0};
        case (b.mode)
            MODE_WR_CUR: cur_mat[b.idx] = b.val;
            MODE_WR_OPR: opr_mat[b.idx] = b.val;
            MODE_IDENT:  load_identity();
            MODE_CONCAT: begin
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++) begin
                        acc = 0;
                        for (int k = 0; k < 4; k++)
                            acc += qmul(cur_mat[r*4+k], opr_mat[k*4+c]);
                        prod_mat[r*4+c] = sat32(acc);
                    end
                cur_mat = prod_mat;
            end
            MODE_INVERT: begin
                // negate translation at 64 bits so the most negative value stays exact
                for (int i = 0; i < 3; i++) negt[i] = -longint'(cur_mat[i*4+3]);
                for (int i = 0; i < 3; i++)
                    for (int k = 0; k < 3; k++) rot[i*3+k] = cur_mat[k*4+i];
                for (int i = 0; i < 3; i++) begin
                    acc = 0;
                    for (int k = 0; k < 3; k++) begin
                        cur_mat[i*4+k] = rot[i*3+k];
                        acc += qmul(negt[k], rot[i*3+k]);
                    end
                    cur_mat[i*4+3] = sat32(acc);
                end
            end
            MODE_XFORM: begin
                vec[0] = b.vx;
                vec[1] = b.vy;
                vec[2] = b.vz;
                for (int r = 0; r < 3; r++) begin
                    acc = cur_mat[r*4+3];
                    for (int k = 0; k < 3; k++) acc += qmul(cur_mat[r*4+k], vec[k]);
                    outv[r] = sat32(acc);
                end
                res   = '{outv[0], outv[1], outv[2]};
                gives = 1'b1;
            end
            default: ;
        endcase
    endtask

    // Present one beat, record its prediction, hold until the engine takes it
    task automatic present_beat(input op_beat_t b, input bit typed, input xyz_t typed_xyz);
        bit   gives;
        xyz_t want;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        engine_step(b, gives, want);
        if (gives) pending_xyz.push_back(typed ? typed_xyz : want);
        s_tvalid <= 1'b1;
        s_tuser  <= b.mode;
        s_tdata  <= {4'h0, b.vz, b.vy, b.vx, b.val, b.idx};
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
            4, 5:       return $urandom;
            6:          return $urandom_range(32'h0002_0000) - 32'h0001_0000;
            7: begin
                case ($urandom_range(3))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return 32'h0;
                    default: return ALL_ONES;
                endcase
            end
            8:          return $urandom_range(1) ? Q_ONE : Q_NEG1;
            default:    return $urandom_range(32'h0200_0000) - 32'h0100_0000;
        endcase
    endfunction

    function automatic op_beat_t rand_beat();
        op_beat_t b;
        int       pick;
        b.idx = 4'($urandom_range(15));
        b.val = rand_q();
        b.vx  = rand_q();
        b.vy  = rand_q();
        b.vz  = rand_q();
        pick  = $urandom_range(99);
        if (pick < 25)      b.mode = MODE_WR_CUR;
        else if (pick < 45) b.mode = MODE_WR_OPR;
        else if (pick < 48) b.mode = MODE_IDENT;
        else if (pick < 52) b.mode = MODE_CONCAT;
        else if (pick < 56) b.mode = MODE_INVERT;
        else if (pick < 58) b.mode = $urandom_range(1) ? MODE_SPARE_6 : MODE_SPARE_7;
        else                b.mode = MODE_XFORM;
        return b;
    endfunction

    task automatic check_result(input logic [95:0] beat);
        xyz_t want;
        if (pending_xyz.size() == 0) begin
            $error("result beat with no transform pending: %h", beat);
            fail_cnt++;
        end else begin
            want = pending_xyz.pop_front();
            if ($signed(beat[31:0]) !== want.x) begin
                $error("out_x: expected %0d, actual %0d", want.x, $signed(beat[31:0]));
                fail_cnt++;
            end
            if ($signed(beat[63:32]) !== want.y) begin
                $error("out_y: expected %0d, actual %0d", want.y, $signed(beat[63:32]));
                fail_cnt++;
            end
            if ($signed(beat[95:64]) !== want.z) begin
                $error("out_z: expected %0d, actual %0d", want.z, $signed(beat[95:64]));
                fail_cnt++;
            end
        end
    endtask

    // Result side: check accepted beats, stall at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_result(m_tdata);
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : stimulus
        op_beat_t b;
        xyz_t     typed_xyz;
        dir_row_t row;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        idle_pct  = 0;
        stall_pct = 0;
        for (int i = 0; i < 16; i++) opr_mat[i] = 32'h0;
        load_identity();

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int n = 0; n < DIR_ROWS; n++) begin
            row       = DIR_TAB[n];
            b.mode    = row.mode;
            b.idx     = row.idx;
            b.val     = row.val;
            b.vx      = row.vx;
            b.vy      = row.vy;
            b.vz      = row.vz;
            typed_xyz = '{row.ex, row.ey, row.ez};
            present_beat(b, row.chk, typed_xyz);
        end

        // Phases: free flow, sparse sender, stalling receiver, both throttled
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 88; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 88; end
                default: begin idle_pct = 33; stall_pct = 33; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) present_beat(rand_beat(), 1'b0, typed_xyz);
        end
        s_tvalid <= 1'b0;

        while (pending_xyz.size() != 0) @(posedge aclk);
        // catch late or spurious beats after the last expected result
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_cnt == 0 && pending_xyz.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/ame_pkg.sv
design/ame_mat_mem.sv
design/ame_mac.sv
design/affine_matrix_engine.sv
design/ame_checker.sv
dv/tb_top.sv
